FILE: src/rtam_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Region table address match package
// Shared constants, types and helper functions for the region lookup unit.
// ----------------------------------------------------------------------------
package rtam_pkg;

  localparam int NUM_PROCESSES     = 16;
  localparam int REGIONS_PER_TABLE = 32;
  localparam int TABLE_COUNT       = NUM_PROCESSES + 1;
  localparam int ENTRY_COUNT       = TABLE_COUNT * REGIONS_PER_TABLE;
  localparam int FIXED_COUNT       = 10;
  localparam int FIXED_REG_COUNT   = 8;

  localparam int PROC_IDX_W  = $clog2(NUM_PROCESSES);
  localparam int REG_IDX_W   = $clog2(REGIONS_PER_TABLE);
  localparam int TBL_W       = $clog2(TABLE_COUNT);
  localparam int ENTRY_IDX_W = TBL_W + REG_IDX_W;
  localparam int FIXED_IDX_W = $clog2(FIXED_COUNT);

  localparam int OP_W     = 2;
  localparam int SLOT_W   = 5;
  localparam int RIDX_W   = 5;
  localparam int ADDR_W   = 24;
  localparam int SIZE_W   = 24;
  localparam int PERM_W   = 8;
  localparam int TYPE_W   = 3;
  localparam int DEV_W    = 8;
  localparam int TARGET_W = 32;
  localparam int SRC_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_LOOKUP    = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_REGION = 2'd1;
  localparam logic [OP_W-1:0] OP_WR_HEADER = 2'd2;

  localparam logic [SRC_W-1:0] SRC_FIXED = 2'd0;
  localparam logic [SRC_W-1:0] SRC_PROC  = 2'd1;
  localparam logic [SRC_W-1:0] SRC_BIOS  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_BIOS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_BASE = 1'd1;

  localparam logic [ADDR_W-1:0] FIXED_REG_BASE    = 24'h700000;
  localparam logic [ADDR_W-1:0] FIXED_STATUS_BASE = 24'h700020;
  localparam logic [ADDR_W-1:0] STACK_BUF_BASE    = 24'h700100;
  localparam logic [SIZE_W-1:0] FIXED_REG_SIZE    = 24'd4;
  localparam logic [SIZE_W-1:0] STACK_BUF_SIZE    = 24'd256;

  localparam logic [PERM_W-1:0] PERM_RD = 8'h01;
  localparam logic [PERM_W-1:0] PERM_RW = 8'h03;
  localparam logic [TYPE_W-1:0] KIND_MEMORY   = 3'd0;
  localparam logic [TYPE_W-1:0] KIND_REGISTER = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_DONE
  } lookup_state_t;

  typedef struct packed {
    logic                valid;
    logic [ADDR_W-1:0]   base;
    logic [SIZE_W-1:0]   size;
    logic [PERM_W-1:0]   perms;
    logic [TYPE_W-1:0]   rtype;
    logic [DEV_W-1:0]    dev;
    logic [TARGET_W-1:0] target;
  } region_entry_t;

  typedef struct packed {
    logic                   we;
    logic [ENTRY_IDX_W-1:0] addr;
    region_entry_t          data;
  } mem_wr_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SLOT_W-1:0]   slot;
    logic [RIDX_W-1:0]   region_index;
    logic [ADDR_W-1:0]   address;
    logic                entry_enabled;
    logic [SIZE_W-1:0]   entry_size;
    logic [PERM_W-1:0]   entry_permissions;
    logic [TYPE_W-1:0]   entry_type;
    logic [DEV_W-1:0]    entry_device;
    logic [TARGET_W-1:0] entry_target;
    logic                use_bios_map;
  } item_t;

  typedef struct packed {
    logic                left_bios;
    logic [TARGET_W-1:0] stack_buffer_base;
  } cfg_t;

  typedef struct packed {
    logic                hit;
    logic [SRC_W-1:0]    source;
    logic [RIDX_W-1:0]   region_number;
    logic [PERM_W-1:0]   permissions;
    logic [TYPE_W-1:0]   region_type;
    logic [DEV_W-1:0]    device_number;
    logic [TARGET_W-1:0] target_address;
    logic [ADDR_W-1:0]   region_base;
  } result_t;

  function automatic logic region_holds(input logic [ADDR_W-1:0] addr,
                                        input logic [ADDR_W-1:0] base,
                                        input logic [SIZE_W-1:0] size);
    logic [ADDR_W:0] hi;
    hi = {1'b0, base} + {1'b0, size};
    return (addr >= base) && ({1'b0, addr} < hi);
  endfunction

  function automatic region_entry_t fixed_entry(input logic [FIXED_IDX_W-1:0] n,
                                                input logic [TARGET_W-1:0] stack_base);
    region_entry_t e;
    e = '0;
    e.valid = 1'b1;
    if (n < FIXED_IDX_W'(FIXED_REG_COUNT)) begin
      e.base  = FIXED_REG_BASE + ADDR_W'({n, 2'b00});
      e.size  = FIXED_REG_SIZE;
      e.perms = PERM_RW;
      e.rtype = KIND_REGISTER;
      e.dev   = DEV_W'(n);
    end else if (n == FIXED_IDX_W'(FIXED_REG_COUNT)) begin
      e.base  = FIXED_STATUS_BASE;
      e.size  = FIXED_REG_SIZE;
      e.perms = PERM_RD;
      e.rtype = KIND_REGISTER;
      e.dev   = DEV_W'(n);
    end else begin
      e.base   = STACK_BUF_BASE;
      e.size   = STACK_BUF_SIZE;
      e.perms  = PERM_RW;
      e.rtype  = KIND_MEMORY;
      e.target = stack_base;
    end
    return e;
  endfunction

  function automatic result_t make_result(input logic [SRC_W-1:0] src,
                                          input logic [RIDX_W-1:0] num,
                                          input region_entry_t e);
    result_t r;
    r.hit            = 1'b1;
    r.source         = src;
    r.region_number  = num;
    r.permissions    = e.perms;
    r.region_type    = e.rtype;
    r.device_number  = e.dev;
    r.target_address = e.target;
    r.region_base    = e.base;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/rtam_region_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Region entry memory
// One write port and one registered read port holding all region tables.
// ----------------------------------------------------------------------------
module rtam_region_mem (
  input  wire logic                            clk,
  input  wire rtam_pkg::mem_wr_t               wr,
  input  wire logic [rtam_pkg::ENTRY_IDX_W-1:0] rd_addr,
  output rtam_pkg::region_entry_t              rd_data
);
  import rtam_pkg::*;

  region_entry_t mem [ENTRY_COUNT];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: src/rtam_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Region lookup sequencer
// Clears the entry memory after reset, executes writes and scans one table
// entry per cycle for lookups.
// ----------------------------------------------------------------------------
module rtam_lookup (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire rtam_pkg::cfg_t                   cfg,
  input  wire logic                             item_valid,
  output logic                                  item_stall,
  input  wire rtam_pkg::item_t                  item,
  output rtam_pkg::mem_wr_t                     mem_wr,
  output logic [rtam_pkg::ENTRY_IDX_W-1:0]      mem_rd_addr,
  input  wire rtam_pkg::region_entry_t          mem_rd_data,
  output logic                                  res_valid,
  input  wire logic                             res_ready,
  output rtam_pkg::result_t                     res
);
  import rtam_pkg::*;

  lookup_state_t state_r, state_nxt;

  logic [ENTRY_IDX_W-1:0] clr_cnt_r;
  item_t                  item_r;
  logic [TBL_W-1:0]       table_r;
  logic [SRC_W-1:0]       src_r;
  logic [REG_IDX_W-1:0]   scan_idx_r;
  result_t                res_r;
  logic                   proc_en_r   [NUM_PROCESSES];
  logic                   proc_bios_r [NUM_PROCESSES];

  logic                   accept;
  logic                   slot_is_proc;
  logic                   use_proc;
  logic [TBL_W-1:0]       table_sel;
  logic                   fix_hit;
  logic [FIXED_IDX_W-1:0] fix_idx;
  region_entry_t          fix_e;
  logic                   scan_hit;
  logic                   scan_last;
  logic                   region_wr_ok;

  assign accept       = item_valid && !item_stall;
  assign slot_is_proc = item_r.slot < SLOT_W'(NUM_PROCESSES);
  assign use_proc     = cfg.left_bios && slot_is_proc &&
                        proc_en_r[item_r.slot[PROC_IDX_W-1:0]] &&
                        !proc_bios_r[item_r.slot[PROC_IDX_W-1:0]];
  assign table_sel    = use_proc ? TBL_W'(item_r.slot[PROC_IDX_W-1:0])
                                 : TBL_W'(NUM_PROCESSES);
  assign scan_hit     = mem_rd_data.valid &&
                        region_holds(item_r.address, mem_rd_data.base, mem_rd_data.size);
  assign scan_last    = scan_idx_r == REG_IDX_W'(REGIONS_PER_TABLE - 1);
  assign region_wr_ok = (item_r.slot <= SLOT_W'(NUM_PROCESSES)) &&
                        (32'(item_r.region_index) < REGIONS_PER_TABLE);

  always_comb begin
    fix_hit = 1'b0;
    fix_idx = '0;
    for (int i = FIXED_COUNT - 1; i >= 0; i--) begin
      if (region_holds(item_r.address,
                       fixed_entry(FIXED_IDX_W'(i), cfg.stack_buffer_base).base,
                       fixed_entry(FIXED_IDX_W'(i), cfg.stack_buffer_base).size)) begin
        fix_hit = 1'b1;
        fix_idx = FIXED_IDX_W'(i);
      end
    end
    fix_e = fixed_entry(fix_idx, cfg.stack_buffer_base);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == ENTRY_IDX_W'(ENTRY_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (item_r.op == OP_LOOKUP && !fix_hit) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    item_stall  = 1'b1;
    mem_wr      = '0;
    mem_rd_addr = {table_r, scan_idx_r + REG_IDX_W'(1)};
    res_valid   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_wr.we   = 1'b1;
        mem_wr.addr = clr_cnt_r;
      end
      ST_IDLE: begin
        item_stall = 1'b0;
      end
      ST_DECODE: begin
        mem_rd_addr = {table_sel, REG_IDX_W'(0)};
        if (item_r.op == OP_WR_REGION && region_wr_ok) begin
          mem_wr.we          = 1'b1;
          mem_wr.addr        = {item_r.slot[TBL_W-1:0], item_r.region_index[REG_IDX_W-1:0]};
          mem_wr.data.valid  = item_r.entry_enabled;
          mem_wr.data.base   = item_r.address;
          mem_wr.data.size   = item_r.entry_size;
          mem_wr.data.perms  = item_r.entry_permissions;
          mem_wr.data.rtype  = item_r.entry_type;
          mem_wr.data.dev    = item_r.entry_device;
          mem_wr.data.target = item_r.entry_target;
        end
      end
      ST_SCAN: begin
      end
      ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      for (int p = 0; p < NUM_PROCESSES; p++) begin
        proc_en_r[p]   <= 1'b0;
        proc_bios_r[p] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ENTRY_IDX_W'(1);
      end
      if (state_r == ST_DECODE && item_r.op == OP_WR_HEADER && slot_is_proc) begin
        proc_en_r[item_r.slot[PROC_IDX_W-1:0]]   <= item_r.entry_enabled;
        proc_bios_r[item_r.slot[PROC_IDX_W-1:0]] <= item_r.use_bios_map;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item;
    end
    case (state_r)
      ST_DECODE: begin
        table_r    <= table_sel;
        src_r      <= use_proc ? SRC_PROC : SRC_BIOS;
        scan_idx_r <= '0;
        if (item_r.op == OP_LOOKUP && fix_hit) begin
          res_r <= make_result(SRC_FIXED, RIDX_W'(fix_idx), fix_e);
        end else begin
          res_r <= '0;
        end
      end
      ST_SCAN: begin
        scan_idx_r <= scan_idx_r + REG_IDX_W'(1);
        if (scan_hit) begin
          res_r <= make_result(src_r, RIDX_W'(scan_idx_r), mem_rd_data);
        end
      end
      default: begin
      end
    endcase
  end

  a_clear_writes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> mem_wr.we)
    else $error("clearing pass skipped a memory write");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr.we |-> (state_r == ST_CLEAR || state_r == ST_DECODE))
    else $error("memory written outside clear or decode");

  a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> ($past(state_r) == ST_DECODE || $past(state_r) == ST_SCAN))
    else $error("table scan entered without decode");

  a_fixed_number: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.hit && res.source == SRC_FIXED) |->
      res.region_number < RIDX_W'(FIXED_COUNT))
    else $error("fixed region number out of range");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_DECODE)
    else $error("accepted beat not decoded");

endmodule
`default_nettype wire

FILE: src/region_table_address_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Region table address match
// Region lookup unit for per-process and BIOS memory region tables.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the in_ channel (valid/stall) and every item returns
//   exactly one result beat on the out_ channel (valid/stall). Region and
//   header writes return an all-zero beat. Configuration writes use the
//   cfg_ channel (valid/ready, always ready) and are applied at once.
//   The block takes one item at a time. A write, or a lookup that hits
//   one of the ten fixed regions, passes the decode and done states and
//   then raises out_valid from the output register. A lookup that falls
//   through to the table reads one entry per cycle from the entry memory
//   until an entry hits or the last of the table's 32 entries is read.
//   A new item is accepted only after the previous one has left the
//   sequencer. The result sits in an output register, so a new beat is
//   accepted while the previous result is still stalled; the next result
//   waits in the sequencer until that register drains.
//   After reset the block sweeps the 544-entry memory to clear all valid
//   bits, one entry per cycle, and holds in_stall high until the sweep
//   is complete. Process headers and configuration clear at reset.
// ----------------------------------------------------------------------------
module region_table_address_match (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [rtam_pkg::OP_W-1:0]          in_op,
  input  wire logic [rtam_pkg::SLOT_W-1:0]        in_slot,
  input  wire logic [rtam_pkg::RIDX_W-1:0]        in_region_index,
  input  wire logic [rtam_pkg::ADDR_W-1:0]        in_address,
  input  wire logic                               in_entry_enabled,
  input  wire logic [rtam_pkg::SIZE_W-1:0]        in_entry_size,
  input  wire logic [rtam_pkg::PERM_W-1:0]        in_entry_permissions,
  input  wire logic [rtam_pkg::TYPE_W-1:0]        in_entry_type,
  input  wire logic [rtam_pkg::DEV_W-1:0]         in_entry_device,
  input  wire logic [rtam_pkg::TARGET_W-1:0]      in_entry_target,
  input  wire logic                               in_use_bios_map,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_hit,
  output logic [rtam_pkg::SRC_W-1:0]              out_source,
  output logic [rtam_pkg::RIDX_W-1:0]             out_region_number,
  output logic [rtam_pkg::PERM_W-1:0]             out_permissions,
  output logic [rtam_pkg::TYPE_W-1:0]             out_region_type,
  output logic [rtam_pkg::DEV_W-1:0]              out_device_number,
  output logic [rtam_pkg::TARGET_W-1:0]           out_target_address,
  output logic [rtam_pkg::ADDR_W-1:0]             out_region_base,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [rtam_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rtam_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rtam_pkg::*;

  cfg_t                   cfg_r;
  item_t                  item;
  mem_wr_t                mem_wr;
  logic [ENTRY_IDX_W-1:0] mem_rd_addr;
  region_entry_t          mem_rd_data;
  logic                   res_valid;
  logic                   res_ready;
  result_t                res;
  logic                   out_valid_r;
  result_t                out_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LEFT_BIOS:  cfg_r.left_bios         <= cfg_data[0];
        CFG_STACK_BASE: cfg_r.stack_buffer_base <= TARGET_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    item.op                = in_op;
    item.slot              = in_slot;
    item.region_index      = in_region_index;
    item.address           = in_address;
    item.entry_enabled     = in_entry_enabled;
    item.entry_size        = in_entry_size;
    item.entry_permissions = in_entry_permissions;
    item.entry_type        = in_entry_type;
    item.entry_device      = in_entry_device;
    item.entry_target      = in_entry_target;
    item.use_bios_map      = in_use_bios_map;
  end

  rtam_region_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  rtam_lookup u_lookup (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .item_valid  (in_valid),
    .item_stall  (in_stall),
    .item        (item),
    .mem_wr      (mem_wr),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_r.hit;
  assign out_source         = out_r.source;
  assign out_region_number  = out_r.region_number;
  assign out_permissions    = out_r.permissions;
  assign out_region_type    = out_r.region_type;
  assign out_device_number  = out_r.device_number;
  assign out_target_address = out_r.target_address;
  assign out_region_base    = out_r.region_base;

endmodule
`default_nettype wire
